/* hw/rtl/assert_macros.svh */
// Assertion macros for the sector cache top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define LWSC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check a consequence in the same cycle as its trigger, outside reset.
`define LWSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lwsc_pkg.sv */
// Shared constants, command codes and cell control types of the sector cache.
package lwsc_pkg;

  localparam int unsigned SLOTS_DEF       = 64;
  localparam int unsigned SECTOR_BITS_DEF = 32;
  localparam int unsigned CMD_W           = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic upd;       // apply the lookup outcome this cycle
    logic hit;       // the lookup hit
    logic is_write;  // the item is a write
    logic age_all;   // fill of an empty slot: every filled slot ages
    logic shift;     // advance the flush token by one cell
  } cell_ctl_t;

  // Status returned by each cell
  typedef struct packed {
    logic valid;
    logic dirty;
    logic match;
    logic vic;
    logic tok;
    logic first_empty;
  } cell_st_t;

endpackage

/* hw/rtl/lwsc_cell.sv */
// One cache slot: tag, dirty mark, recency rank, fill flag and flush token.
module lwsc_cell import lwsc_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned SECTOR_BITS = SECTOR_BITS_DEF,
  localparam int unsigned RANK_W     = $clog2(SLOTS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctl_t              ctl,
  input  logic [SECTOR_BITS-1:0] sector,
  input  logic [RANK_W-1:0]      rank_ref,
  input  logic                   sel,
  input  logic                   tok_in,
  input  logic                   prev_valid,
  output cell_st_t               st,
  output logic [RANK_W-1:0]      rank,
  output logic [SECTOR_BITS-1:0] tag
);

  logic                   valid_r;
  logic                   dirty_r;
  logic                   tok_r;
  logic                   match_r;
  logic                   vic_r;
  logic [RANK_W-1:0]      rank_r;
  logic [SECTOR_BITS-1:0] tag_r;

  // Control state: fill flag, dirty mark, token, registered compares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      tok_r   <= 1'b0;
      match_r <= 1'b0;
      vic_r   <= 1'b0;
    end else begin
      match_r <= valid_r && (tag_r == sector);
      vic_r   <= valid_r && (rank_r == RANK_W'(SLOTS - 1));
      if (ctl.shift) begin
        tok_r <= tok_in;
      end
      if (ctl.upd && sel) begin
        valid_r <= 1'b1;
        dirty_r <= ctl.hit ? (dirty_r | ctl.is_write) : ctl.is_write;
      end else if (ctl.shift && tok_r) begin
        dirty_r <= 1'b0;
      end
    end
  end

  // Payload: tag on a fill, rank to front or aged by one
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      if (sel) begin
        rank_r <= '0;
        if (!ctl.hit) begin
          tag_r <= sector;
        end
      end else if (valid_r && (ctl.age_all || (rank_r < rank_ref))) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  assign st.valid       = valid_r;
  assign st.dirty       = dirty_r;
  assign st.match       = match_r;
  assign st.vic         = vic_r;
  assign st.tok         = tok_r;
  assign st.first_empty = prev_valid & ~valid_r;
  assign rank           = rank_r;
  assign tag            = tag_r;

endmodule

/* hw/rtl/lru_writeback_sector_cache.sv */
// A read or write gives its result after its transfer is taken, in these steps:
//   tag compare in every cell, slot choice, rank update, output load.
// A new item is taken only in idle, after the last result is loaded; a flush walks a token
//   down the row of SLOTS cells, one cell per cycle unless a write-back waits on the output.
// Reset clears fill flags, dirty marks and tokens at once; tags and ranks are not
//   cleared and no clearing pass runs, so input is taken from the first cycle.
`include "assert_macros.svh"
module lru_writeback_sector_cache import lwsc_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned SECTOR_BITS = SECTOR_BITS_DEF,
  localparam int unsigned SLOT_W     = $clog2(SLOTS),
  localparam int unsigned IN_W       = ((SECTOR_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW     = SLOT_W + 3 + SECTOR_BITS,
  localparam int unsigned OUT_W      = ((OUT_DW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sector
  input  logic [CMD_W-1:0] in_tuser,   // cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // slot, hit, fill_needed, write_back, write_back_sector
  output logic             out_tlast   // last
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOK   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_FLUSH  = 7'b0100000,
    S_FEND   = 7'b1000000
  } state_t;

  state_t                 state_r;
  logic [SECTOR_BITS-1:0] sector_r;
  logic                   is_write_r;
  logic                   hit_r;
  logic [SLOTS-1:0]       sel_r;

  logic [SLOT_W-1:0]      res_slot_r;
  logic                   res_hit_r;
  logic                   res_fill_r;
  logic                   res_wb_r;
  logic [SECTOR_BITS-1:0] res_tag_r;

  logic                   pend_v_r;
  logic [SLOT_W-1:0]      pend_slot_r;
  logic [SECTOR_BITS-1:0] pend_tag_r;

  logic                   out_tvalid_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic                   out_hit_r;
  logic                   out_fill_r;
  logic                   out_wb_r;
  logic [SECTOR_BITS-1:0] out_tag_r;
  logic                   out_last_r;

  logic [SECTOR_BITS-1:0] sector_in;
  cmd_t                   cmd_in;
  logic                   accept;
  logic                   accept_flush;

  cell_ctl_t              ctl;
  cell_st_t               st      [SLOTS];
  logic [SLOT_W-1:0]      rank_v  [SLOTS];
  logic [SECTOR_BITS-1:0] tag_v   [SLOTS];
  logic [SLOTS-1:0]       valid_v;
  logic [SLOTS-1:0]       dirty_v;
  logic [SLOTS-1:0]       match_v;
  logic [SLOTS-1:0]       vic_v;
  logic [SLOTS-1:0]       tok_v;
  logic [SLOTS-1:0]       empty_v;
  logic [SLOTS-1:0]       tokd_v;

  logic                   full;
  logic                   any_match;
  logic [SLOTS-1:0]       sel_nxt;
  logic [SLOT_W-1:0]      rank_ref;
  logic [SLOT_W-1:0]      sel_slot;
  logic [SECTOR_BITS-1:0] old_tag;
  logic                   old_dirty;
  logic                   found;
  logic [SLOT_W-1:0]      fl_slot;
  logic [SECTOR_BITS-1:0] fl_tag;
  logic                   adv;
  logic                   out_free;

  logic                   ld;
  logic [SLOT_W-1:0]      ld_slot;
  logic                   ld_hit;
  logic                   ld_fill;
  logic                   ld_wb;
  logic [SECTOR_BITS-1:0] ld_tag;
  logic                   ld_last;

  // Unpack the input transfer
  assign sector_in    = in_tdata[SECTOR_BITS-1:0];
  assign cmd_in       = cmd_t'(in_tuser);
  assign in_tready    = (state_r == S_IDLE);
  assign accept       = in_tvalid && in_tready;
  assign accept_flush = accept && (cmd_in == CMD_FLUSH);

  // Row of slot cells; fill flag and token pass from each cell to the next
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic prev_valid;
    logic tok_in;
    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign tok_in     = accept_flush;
    end else begin : g_link
      assign prev_valid = st[g-1].valid;
      assign tok_in     = st[g-1].tok;
    end
    lwsc_cell #(
      .SLOTS       (SLOTS),
      .SECTOR_BITS (SECTOR_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sector     (sector_r),
      .rank_ref   (rank_ref),
      .sel        (sel_r[g]),
      .tok_in     (tok_in),
      .prev_valid (prev_valid),
      .st         (st[g]),
      .rank       (rank_v[g]),
      .tag        (tag_v[g])
    );
    assign valid_v[g] = st[g].valid;
    assign dirty_v[g] = st[g].dirty;
    assign match_v[g] = st[g].match;
    assign vic_v[g]   = st[g].vic;
    assign tok_v[g]   = st[g].tok;
    assign empty_v[g] = st[g].first_empty;
  end

  assign tokd_v    = tok_v & dirty_v;
  assign full      = valid_v[SLOTS-1];
  assign any_match = |match_v;
  assign found     = |tokd_v;
  assign sel_nxt   = any_match ? match_v : (full ? vic_v : empty_v);

  // One-hot selections: rank, tag and index of the chosen or flushed slot
  always_comb begin
    rank_ref  = '0;
    sel_slot  = '0;
    old_tag   = '0;
    fl_slot   = '0;
    fl_tag    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_r[i]) begin
        rank_ref = rank_ref | rank_v[i];
        sel_slot = sel_slot | SLOT_W'(i);
        old_tag  = old_tag | tag_v[i];
      end
      if (tokd_v[i]) begin
        fl_slot = fl_slot | SLOT_W'(i);
        fl_tag  = fl_tag | tag_v[i];
      end
    end
  end
  assign old_dirty = |(sel_r & dirty_v);

  // Cell control broadcast
  assign out_free    = !out_tvalid_r || out_tready;
  assign adv         = !(found && pend_v_r && !out_free);
  assign ctl.upd     = (state_r == S_UPDATE);
  assign ctl.hit     = hit_r;
  assign ctl.is_write = is_write_r;
  assign ctl.age_all = !hit_r && !full;
  assign ctl.shift   = accept_flush || ((state_r == S_FLUSH) && adv);

  // Output register load: lookup result, pending flush entry, or closing result
  always_comb begin
    ld      = 1'b0;
    ld_slot = '0;
    ld_hit  = 1'b0;
    ld_fill = 1'b0;
    ld_wb   = 1'b0;
    ld_tag  = '0;
    ld_last = 1'b0;
    unique case (state_r)
      S_EMIT: begin
        ld      = out_free;
        ld_slot = res_slot_r;
        ld_hit  = res_hit_r;
        ld_fill = res_fill_r;
        ld_wb   = res_wb_r;
        ld_tag  = res_tag_r;
        ld_last = 1'b1;
      end
      S_FLUSH: begin
        ld      = adv && found && pend_v_r;
        ld_slot = pend_slot_r;
        ld_wb   = 1'b1;
        ld_tag  = pend_tag_r;
      end
      S_FEND: begin
        ld      = out_free;
        ld_slot = pend_v_r ? pend_slot_r : '0;
        ld_wb   = pend_v_r;
        ld_tag  = pend_v_r ? pend_tag_r : '0;
        ld_last = 1'b1;
      end
      S_IDLE, S_LOOK, S_DECIDE, S_UPDATE: begin
        ld = 1'b0;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_in) inside
              CMD_READ, CMD_WRITE: state_r <= S_LOOK;
              CMD_FLUSH:           state_r <= S_FLUSH;
              default:             state_r <= S_IDLE;
            endcase
          end
        end
        S_LOOK:   state_r <= S_DECIDE;
        S_DECIDE: state_r <= S_UPDATE;
        S_UPDATE: state_r <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (adv) begin
            if (found) begin
              pend_v_r <= 1'b1;
            end
            if (tok_v[SLOTS-1]) begin
              state_r <= S_FEND;
            end
          end
        end
        S_FEND: begin
          if (out_free) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Item, slot choice, result and pending flush payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sector_r   <= sector_in;
      is_write_r <= (cmd_in == CMD_WRITE);
    end
    if (state_r == S_DECIDE) begin
      sel_r <= sel_nxt;
      hit_r <= any_match;
    end
    if (state_r == S_UPDATE) begin
      res_slot_r <= sel_slot;
      res_hit_r  <= hit_r;
      res_fill_r <= !hit_r && !is_write_r;
      res_wb_r   <= !hit_r && old_dirty;
      res_tag_r  <= (!hit_r && old_dirty) ? old_tag : '0;
    end
    if ((state_r == S_FLUSH) && adv && found) begin
      pend_slot_r <= fl_slot;
      pend_tag_r  <= fl_tag;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_slot_r <= ld_slot;
      out_hit_r  <= ld_hit;
      out_fill_r <= ld_fill;
      out_wb_r   <= ld_wb;
      out_tag_r  <= ld_tag;
      out_last_r <= ld_last;
    end
  end

  // Pack the result transfer
  always_comb begin
    out_tdata                            = '0;
    out_tdata[SLOT_W-1:0]                = out_slot_r;
    out_tdata[SLOT_W]                    = out_hit_r;
    out_tdata[SLOT_W+1]                  = out_fill_r;
    out_tdata[SLOT_W+2]                  = out_wb_r;
    out_tdata[SLOT_W+3 +: SECTOR_BITS]   = out_tag_r;
  end
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;

  // Tags of filled slots are unique, so at most one cell matches
  `LWSC_ASSERT_ALWAYS(a_match_unique, $onehot0(match_v), "several slots match one sector")
  // Slots fill in order from the first cell up
  `LWSC_ASSERT_ALWAYS(a_fill_order, $onehot0(valid_v ^ (valid_v >> 1)), "fill flags out of order")
  // Exactly one slot is chosen when the lookup is applied
  `LWSC_ASSERT_IMPL(a_one_slot, state_r == S_UPDATE, $onehot(sel_r), "slot choice not one-hot")
  // At most one flush token travels along the row
  `LWSC_ASSERT_ALWAYS(a_one_token, $onehot0(tok_v), "several flush tokens")

endmodule
